// File: rtl/spce_pkg.sv
// ----------------------------------------------------------------------------
// spce_pkg
// Shared types and constants of the serial programming command engine.
// ----------------------------------------------------------------------------
`default_nettype none

package spce_pkg;

  localparam int FLASH_PAGE_BYTES_DEF   = 256;
  localparam int FLASH_ADDRESS_BITS_DEF = 25;
  localparam int MAX_RES                = 7;

  typedef enum logic [2:0] {
    K_SEND   = 3'd0,
    K_FILL   = 3'd1,
    K_PWRITE = 3'd2,
    K_ERASE  = 3'd3,
    K_EWRITE = 3'd4,
    K_FREAD  = 3'd5,
    K_EREAD  = 3'd6,
    K_START  = 3'd7
  } kind_t;

  // register indexes of the configuration port
  localparam logic [2:0] REG_BLOCK_LIMIT = 3'd0;
  localparam logic [2:0] REG_BOOT_START  = 3'd1;
  localparam logic [2:0] REG_SIGNATURE   = 3'd2;
  localparam logic [2:0] REG_DEVICE      = 3'd3;
  localparam logic [2:0] REG_VERSION     = 3'd4;
  localparam logic [2:0] REG_IDENT       = 3'd5;
  localparam logic [2:0] REG_EXIT_ON_E   = 3'd6;
  localparam logic [2:0] REG_EXT_ADDR    = 3'd7;

  typedef struct packed {
    logic [15:0] block_limit;
    logic [24:0] boot_base;
    logic [23:0] signature_bytes;
    logic [7:0]  device_code;
    logic [15:0] version_bytes;
    logic [39:0] identifier_prefix;
    logic        exit_on_e;
    logic        extended_address_enable;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [24:0] addr;
    logic [15:0] pay;
  } res_t;

  // all results of one input transaction
  typedef struct packed {
    logic [2:0]         cnt;
    res_t [MAX_RES-1:0] ent;
  } desc_t;

  function automatic desc_t add_res(desc_t d, kind_t k, logic [24:0] a, logic [15:0] p);
    desc_t r;
    r = d;
    if (d.cnt != 3'(MAX_RES)) begin
      r.ent[d.cnt] = '{kind: k, addr: a, pay: p};
      r.cnt = d.cnt + 3'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/serial_programming_command_engine.sv
// ----------------------------------------------------------------------------
// serial_programming_command_engine
// Bootloader-style command engine: serial bytes and memory acks in, reply
// bytes and memory requests out.
// ----------------------------------------------------------------------------
// usage
//   in channel: in_opcode 0 carries a received serial byte in in_value[7:0],
//   in_opcode 1 a memory acknowledgement with read data in in_value.
//   out channel: one result per transaction, kind/mem_address/payload, and
//   out_last flags the final result caused by an input transaction.
//   cfg port: cfg_we with cfg_index/cfg_data writes one register; write only
//   while the engine is idle.
// flow
//   the decoder takes one input a cycle while the queue is not full; with
//   the emitter idle its first result goes from the queue slot through the
//   emitter's list register to the output register; results then leave at
//   one per cycle unless out_stall holds them; the next list loads as the
//   last one of a list is sent; a two-entry queue lets the decoder run ahead.
// reset and stall
//   rst_n low (synchronous) returns the parser to idle and loads register
//   defaults; out_stall holds the output register, the queue fills, then
//   in_stall rises until room frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_programming_command_engine #(
  parameter int FLASH_PAGE_BYTES   = spce_pkg::FLASH_PAGE_BYTES_DEF,
  parameter int FLASH_ADDRESS_BITS = spce_pkg::FLASH_ADDRESS_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_opcode,
  input  wire logic [15:0] in_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_kind,
  output logic [24:0]      out_mem_address,
  output logic [15:0]      out_payload,
  output logic             out_last,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [39:0] cfg_data
);
  import spce_pkg::*;

  cfg_t  cfg_r;
  logic  q_full, q_push, q_pop, q_valid, back_busy;
  desc_t q_in, q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_limit             <= 16'd256;
      cfg_r.boot_base               <= 25'd61440;
      cfg_r.signature_bytes         <= '0;
      cfg_r.device_code             <= '0;
      cfg_r.version_bytes           <= '0;
      cfg_r.identifier_prefix       <= '0;
      cfg_r.exit_on_e               <= 1'b0;
      cfg_r.extended_address_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLOCK_LIMIT: cfg_r.block_limit             <= cfg_data[15:0];
        REG_BOOT_START:  cfg_r.boot_base               <= cfg_data[24:0];
        REG_SIGNATURE:   cfg_r.signature_bytes         <= cfg_data[23:0];
        REG_DEVICE:      cfg_r.device_code             <= cfg_data[7:0];
        REG_VERSION:     cfg_r.version_bytes           <= cfg_data[15:0];
        REG_IDENT:       cfg_r.identifier_prefix       <= cfg_data;
        REG_EXIT_ON_E:   cfg_r.exit_on_e               <= cfg_data[0];
        REG_EXT_ADDR:    cfg_r.extended_address_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // front: decode and protocol state
  spce_front #(
    .FLASH_PAGE_BYTES  (FLASH_PAGE_BYTES),
    .FLASH_ADDRESS_BITS(FLASH_ADDRESS_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_opcode(in_opcode),
    .in_value (in_value),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_desc   (q_in)
  );

  // result lists waiting for the emitter
  spce_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_desc(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .head     (q_head)
  );

  // back: one result per cycle into the output register unless out_stall holds it
  spce_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .head           (q_head),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_mem_address(out_mem_address),
    .out_payload    (out_payload),
    .out_last       (out_last),
    .busy           (back_busy)
  );

`ifndef NO_ASSERTIONS
  // decoder never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("queue overflow");

  // queued lists are never empty
  a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_in.cnt != 3'd0))
    else $error("empty result list pushed");

  // pop only happens with data present
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  // a result shows up only while the emitter has or just had work
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(back_busy))
    else $error("result without source");
`endif

endmodule

`default_nettype wire

// File: rtl/spce_front.sv
// ----------------------------------------------------------------------------
// spce_front
// Command decoder: takes one input transaction a cycle while the queue is not
// full, updates the protocol state and pushes the list of results it causes into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module spce_front #(
  parameter int FLASH_PAGE_BYTES   = spce_pkg::FLASH_PAGE_BYTES_DEF,
  parameter int FLASH_ADDRESS_BITS = spce_pkg::FLASH_ADDRESS_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic           in_opcode,
  input  wire logic [15:0]    in_value,
  input  wire spce_pkg::cfg_t cfg,
  input  wire logic           q_full,
  output logic                q_push,
  output spce_pkg::desc_t     q_desc
);
  import spce_pkg::*;

  localparam logic [25:0] FlashSize = 26'd1 << FLASH_ADDRESS_BITS;
  localparam logic [24:0] FlashMask = 25'(FlashSize - 26'd1);
  localparam logic [25:0] PageBytes = 26'(FLASH_PAGE_BYTES);

  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_Y  = 8'h59;
  localparam logic [7:0] CH_Q  = 8'h3f;
  localparam logic [7:0] CH_S  = 8'h53;
  localparam logic [7:0] CH_F  = 8'h46;
  localparam logic [7:0] CH_E  = 8'h45;

  localparam logic [7:0] CMD_NUL = 8'h00;
  localparam logic [7:0] CMD_P   = 8'h50;
  localparam logic [7:0] CMD_L   = 8'h4c;
  localparam logic [7:0] CMD_E   = 8'h45;
  localparam logic [7:0] CMD_X   = 8'h58;
  localparam logic [7:0] CMD_LA  = 8'h61;
  localparam logic [7:0] CMD_A   = 8'h41;
  localparam logic [7:0] CMD_H   = 8'h48;
  localparam logic [7:0] CMD_LE  = 8'h65;
  localparam logic [7:0] CMD_T   = 8'h54;
  localparam logic [7:0] CMD_LS  = 8'h73;
  localparam logic [7:0] CMD_LT  = 8'h74;
  localparam logic [7:0] CMD_S   = 8'h53;
  localparam logic [7:0] CMD_V   = 8'h56;
  localparam logic [7:0] CMD_LP  = 8'h70;
  localparam logic [7:0] CMD_LB  = 8'h62;
  localparam logic [7:0] CMD_B   = 8'h42;
  localparam logic [7:0] CMD_LG  = 8'h67;

  typedef enum logic [4:0] {
    PH_IDLE, PH_A1, PH_A2, PH_H1, PH_H2, PH_H3, PH_T, PH_B1, PH_B2, PH_BTYPE,
    PH_FLO, PH_FHI, PH_EDATA, PH_G1, PH_G2, PH_GTYPE, PH_ERASE, PH_RDF, PH_RDE
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [24:0] flash_r, flash_nxt;
  logic [15:0] eep_r, eep_nxt;
  logic [15:0] blen_r, blen_nxt;
  logic [15:0] items_r, items_nxt;
  logic [24:0] walk_r, walk_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        ackp_r, ackp_nxt;

  logic        accept;
  logic [7:0]  b;
  logic [25:0] erase_lim;
  logic [25:0] next_page;
  logic [16:0] half_up;
  desc_t       d;

  assign accept    = in_valid && !q_full;
  assign in_stall  = q_full;
  assign b         = in_value[7:0];
  assign erase_lim = ({1'b0, cfg.boot_base} < FlashSize) ?
                     {1'b0, cfg.boot_base} : FlashSize;
  assign next_page = {1'b0, walk_r} + PageBytes;
  assign half_up   = ({1'b0, blen_r} + 17'd1) >> 1;

  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    flash_nxt = flash_r;
    eep_nxt   = eep_r;
    blen_nxt  = blen_r;
    items_nxt = items_r;
    walk_nxt  = walk_r;
    held_nxt  = held_r;
    ackp_nxt  = ackp_r;
    d         = '0;

    if (in_opcode) begin
      if (ackp_r) begin
        ackp_nxt = 1'b0;
        case (phase_r)
          PH_ERASE: begin
            if (next_page < erase_lim) begin
              walk_nxt = next_page[24:0];
              d = add_res(d, K_ERASE, next_page[24:0], 16'd0);
              ackp_nxt = 1'b1;
            end else begin
              flash_nxt = next_page[24:0] & FlashMask;
              d = add_res(d, K_SEND, 25'd0, {8'd0, CH_CR});
              phase_nxt = PH_IDLE;
            end
          end
          PH_RDF: begin
            d = add_res(d, K_SEND, 25'd0, {8'd0, in_value[7:0]});
            d = add_res(d, K_SEND, 25'd0, {8'd0, in_value[15:8]});
            flash_nxt = (flash_r + 25'd2) & FlashMask;
            items_nxt = items_r - 16'd1;
            if (items_r != 16'd1) begin
              d = add_res(d, K_FREAD, flash_nxt, 16'd0);
              ackp_nxt = 1'b1;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_RDE: begin
            d = add_res(d, K_SEND, 25'd0, {8'd0, in_value[7:0]});
            eep_nxt   = eep_r + 16'd1;
            items_nxt = items_r - 16'd1;
            if (items_r != 16'd1) begin
              d = add_res(d, K_EREAD, {9'd0, eep_nxt}, 16'd0);
              ackp_nxt = 1'b1;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end else if (!ackp_r) begin
      case (phase_r)
        PH_IDLE: begin
          cmd_nxt = b;
          case (b)
            CMD_P, CMD_L: d = add_res(d, K_SEND, 25'd0, {8'd0, CH_CR});
            CMD_E: begin
              d = add_res(d, K_SEND, 25'd0, {8'd0, CH_CR});
              if (cfg.exit_on_e) d = add_res(d, K_START, 25'd0, 16'd0);
            end
            CMD_NUL, CMD_X: begin
              d = add_res(d, K_SEND, 25'd0, {8'd0, CH_CR});
              d = add_res(d, K_START, 25'd0, 16'd0);
            end
            CMD_LA: d = add_res(d, K_SEND, 25'd0, {8'd0, CH_Y});
            CMD_A:  phase_nxt = PH_A1;
            CMD_H: begin
              if (cfg.extended_address_enable) phase_nxt = PH_H1;
              else d = add_res(d, K_SEND, 25'd0, {8'd0, CH_Q});
            end
            CMD_LE: begin
              walk_nxt = 25'd0;
              if (erase_lim != 26'd0) begin
                d = add_res(d, K_ERASE, 25'd0, 16'd0);
                ackp_nxt  = 1'b1;
                phase_nxt = PH_ERASE;
              end else begin
                flash_nxt = 25'd0;
                d = add_res(d, K_SEND, 25'd0, {8'd0, CH_CR});
              end
            end
            CMD_T: phase_nxt = PH_T;
            CMD_LS: begin
              d = add_res(d, K_SEND, 25'd0, {8'd0, cfg.signature_bytes[23:16]});
              d = add_res(d, K_SEND, 25'd0, {8'd0, cfg.signature_bytes[15:8]});
              d = add_res(d, K_SEND, 25'd0, {8'd0, cfg.signature_bytes[7:0]});
            end
            CMD_LT: begin
              d = add_res(d, K_SEND, 25'd0, {8'd0, cfg.device_code});
              d = add_res(d, K_SEND, 25'd0, 16'd0);
            end
            CMD_S: begin
              d = add_res(d, K_SEND, 25'd0, {8'd0, cfg.identifier_prefix[39:32]});
              d = add_res(d, K_SEND, 25'd0, {8'd0, cfg.identifier_prefix[31:24]});
              d = add_res(d, K_SEND, 25'd0, {8'd0, cfg.identifier_prefix[23:16]});
              d = add_res(d, K_SEND, 25'd0, {8'd0, cfg.identifier_prefix[15:8]});
              d = add_res(d, K_SEND, 25'd0, {8'd0, cfg.identifier_prefix[7:0]});
              d = add_res(d, K_SEND, 25'd0, {8'd0, cfg.version_bytes[15:8]});
              d = add_res(d, K_SEND, 25'd0, {8'd0, cfg.version_bytes[7:0]});
            end
            CMD_V: begin
              d = add_res(d, K_SEND, 25'd0, {8'd0, cfg.version_bytes[15:8]});
              d = add_res(d, K_SEND, 25'd0, {8'd0, cfg.version_bytes[7:0]});
            end
            CMD_LP: d = add_res(d, K_SEND, 25'd0, {8'd0, CH_S});
            CMD_LB: begin
              d = add_res(d, K_SEND, 25'd0, {8'd0, CH_Y});
              d = add_res(d, K_SEND, 25'd0, {8'd0, cfg.block_limit[15:8]});
              d = add_res(d, K_SEND, 25'd0, {8'd0, cfg.block_limit[7:0]});
            end
            CMD_B:  phase_nxt = PH_B1;
            CMD_LG: phase_nxt = PH_G1;
            default: d = add_res(d, K_SEND, 25'd0, {8'd0, CH_Q});
          endcase
        end
        PH_A1: begin
          held_nxt  = b;
          phase_nxt = PH_A2;
        end
        PH_A2: begin
          eep_nxt   = {held_r, b};
          flash_nxt = {8'd0, held_r, b, 1'b0} & FlashMask;
          d = add_res(d, K_SEND, 25'd0, {8'd0, CH_CR});
          phase_nxt = PH_IDLE;
        end
        PH_H1: begin
          walk_nxt  = {1'b0, b, 16'd0};
          phase_nxt = PH_H2;
        end
        PH_H2: begin
          walk_nxt  = walk_r | {9'd0, b, 8'd0};
          phase_nxt = PH_H3;
        end
        PH_H3: begin
          walk_nxt  = walk_r | {17'd0, b};
          flash_nxt = {walk_nxt[23:0], 1'b0} & FlashMask;
          eep_nxt   = 16'd0;
          d = add_res(d, K_SEND, 25'd0, {8'd0, CH_CR});
          phase_nxt = PH_IDLE;
        end
        PH_T: begin
          d = add_res(d, K_SEND, 25'd0, {8'd0, CH_CR});
          phase_nxt = PH_IDLE;
        end
        PH_B1, PH_G1: begin
          held_nxt  = b;
          phase_nxt = (phase_r == PH_B1) ? PH_B2 : PH_G2;
        end
        PH_B2: begin
          blen_nxt = {held_r, b};
          if ({held_r, b} > cfg.block_limit) begin
            d = add_res(d, K_SEND, 25'd0, {8'd0, CH_Q});
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_BTYPE;
          end
        end
        PH_BTYPE: begin
          if (b == CH_F) begin
            if (flash_r > cfg.boot_base) d = add_res(d, K_SEND, 25'd0, 16'd0);
            walk_nxt  = flash_r;
            items_nxt = blen_r >> 1;
            if (blen_r[15:1] == 15'd0) begin
              // flash block without a whole word: page write straight away
              d = add_res(d, K_PWRITE, flash_r, 16'd0);
              flash_nxt = flash_r & FlashMask;
              d = add_res(d, K_SEND, 25'd0, {8'd0, CH_CR});
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt = PH_FLO;
            end
          end else if (b == CH_E) begin
            items_nxt = blen_r;
            if (blen_r == 16'd0) begin
              d = add_res(d, K_SEND, 25'd0, {8'd0, CH_CR});
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt = PH_EDATA;
            end
          end else begin
            d = add_res(d, K_SEND, 25'd0, {8'd0, CH_Q});
            phase_nxt = PH_IDLE;
          end
        end
        PH_FLO: begin
          held_nxt  = b;
          phase_nxt = PH_FHI;
        end
        PH_FHI: begin
          d = add_res(d, K_FILL, walk_r, {b, held_r});
          walk_nxt  = (walk_r + 25'd2) & FlashMask;
          items_nxt = items_r - 16'd1;
          if (items_r == 16'd1) begin
            d = add_res(d, K_PWRITE, flash_r, 16'd0);
            flash_nxt = walk_nxt;
            d = add_res(d, K_SEND, 25'd0, {8'd0, CH_CR});
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_FLO;
          end
        end
        PH_EDATA: begin
          d = add_res(d, K_EWRITE, {9'd0, eep_r}, {8'd0, b});
          eep_nxt   = eep_r + 16'd1;
          items_nxt = items_r - 16'd1;
          if (items_r == 16'd1) begin
            d = add_res(d, K_SEND, 25'd0, {8'd0, CH_CR});
            phase_nxt = PH_IDLE;
          end
        end
        PH_G2: begin
          blen_nxt  = {held_r, b};
          phase_nxt = PH_GTYPE;
        end
        PH_GTYPE: begin
          phase_nxt = PH_IDLE;
          if (b == CH_F) begin
            items_nxt = half_up[15:0];
            if (half_up != 17'd0) begin
              d = add_res(d, K_FREAD, flash_r, 16'd0);
              ackp_nxt  = 1'b1;
              phase_nxt = PH_RDF;
            end
          end else if (b == CH_E) begin
            items_nxt = blen_r;
            if (blen_r != 16'd0) begin
              d = add_res(d, K_EREAD, {9'd0, eep_r}, 16'd0);
              ackp_nxt  = 1'b1;
              phase_nxt = PH_RDE;
            end
          end else begin
            d = add_res(d, K_SEND, 25'd0, {8'd0, CH_Q});
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  assign q_push = accept && (d.cnt != 3'd0);
  assign q_desc = d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cmd_r   <= '0;
      flash_r <= '0;
      eep_r   <= '0;
      blen_r  <= '0;
      items_r <= '0;
      walk_r  <= '0;
      held_r  <= '0;
      ackp_r  <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      flash_r <= flash_nxt;
      eep_r   <= eep_nxt;
      blen_r  <= blen_nxt;
      items_r <= items_nxt;
      walk_r  <= walk_nxt;
      held_r  <= held_nxt;
      ackp_r  <= ackp_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/spce_queue.sv
// ----------------------------------------------------------------------------
// spce_queue
// Two-entry queue of result lists between decoder and emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module spce_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire spce_pkg::desc_t push_desc,
  output logic                 full,
  input  wire logic            pop,
  output logic                 q_valid,
  output spce_pkg::desc_t      head
);
  import spce_pkg::*;

  desc_t       slot_r [2];
  logic        wptr_r, rptr_r;
  logic [1:0]  cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign head    = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wptr_r] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// File: rtl/spce_back.sv
// ----------------------------------------------------------------------------
// spce_back
// Result emitter: walks each queued result list into the output register,
// one result a cycle while out_stall does not hold a valid output.
// ----------------------------------------------------------------------------
`default_nettype none

module spce_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  input  wire spce_pkg::desc_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [2:0]           out_kind,
  output logic [24:0]          out_mem_address,
  output logic [15:0]          out_payload,
  output logic                 out_last,
  output logic                 busy
);
  import spce_pkg::*;

  desc_t       cur_r;
  logic        cur_v_r;
  logic [2:0]  idx_r;
  logic        ov_r;
  res_t        o_r;
  logic        olast_r;
  logic        adv;
  logic        fin;

  assign adv       = !ov_r || !out_stall;
  assign fin       = adv && cur_v_r && (idx_r == cur_r.cnt - 3'd1);
  assign pop       = q_valid && (!cur_v_r || fin);
  assign out_valid = ov_r;
  assign out_kind  = o_r.kind;
  assign out_mem_address = o_r.addr;
  assign out_payload     = o_r.pay;
  assign out_last        = olast_r;
  assign busy            = cur_v_r;

  always_ff @(posedge clk) begin
    if (adv && cur_v_r) begin
      o_r     <= cur_r.ent[idx_r];
      olast_r <= (idx_r == cur_r.cnt - 3'd1);
    end
    if (pop) cur_r <= head;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      idx_r   <= 3'd0;
      ov_r    <= 1'b0;
    end else begin
      if (adv) ov_r <= cur_v_r;
      if (pop) begin
        cur_v_r <= 1'b1;
        idx_r   <= 3'd0;
      end else if (fin) begin
        cur_v_r <= 1'b0;
      end else if (adv && cur_v_r) begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

endmodule

`default_nettype wire

// File: tb/serial_programming_command_engine_test.sv
// ----------------------------------------------------------------------------
// serial_programming_command_engine_test
// Drives serial command bytes and memory acks into the command engine with
// random gaps and output stalls, predicts every reply and memory request,
// and checks each result field by field against the prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_programming_command_engine_test;
  import spce_pkg::*;

  localparam int PAGE_BYTES = 256;
  localparam logic [24:0] FLASH_MASK = 25'h1FF_FFFF;
  localparam int CYCLE_LIMIT = 1500000;

  // parser phases of the predictor
  typedef enum int {
    P_IDLE, P_A1, P_A2, P_H1, P_H2, P_H3, P_T, P_B1, P_B2, P_BTYPE,
    P_FLO, P_FHI, P_EDATA, P_G1, P_G2, P_GTYPE, P_ERASE, P_RDF, P_RDE
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [24:0] addr;
    logic [15:0] pay;
    logic        last;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_opcode = 1'b0;
  logic [15:0] in_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_kind;
  logic [24:0] out_mem_address;
  logic [15:0] out_payload;
  logic        out_last;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [39:0] cfg_data = '0;

  int errors = 0;
  int cycles = 0;
  int results_seen = 0;
  bit stall_mode = 1'b1;

  always #6 clk = ~clk;

  serial_programming_command_engine dut (.*);

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  // predictor of the engine plus the queue of pending replies
  class engine_scoreboard;
    cfg_t        regs;
    phase_t      phase;
    logic [24:0] flash_addr, walk;
    logic [15:0] ee_addr, blen, remain;
    logic [7:0]  held;
    bit          ack_wait;
    reply_t      pending[$];
    reply_t      batch[$];

    function new();
      regs = '0;
      regs.block_limit = 16'd256;
      regs.boot_base = 25'd61440;
      phase = P_IDLE; flash_addr = 0; walk = 0; ee_addr = 0;
      blen = 0; remain = 0; held = 0; ack_wait = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [39:0] d);
      case (idx)
        REG_BLOCK_LIMIT: regs.block_limit = d[15:0];
        REG_BOOT_START:  regs.boot_base = d[24:0];
        REG_SIGNATURE:   regs.signature_bytes = d[23:0];
        REG_DEVICE:      regs.device_code = d[7:0];
        REG_VERSION:     regs.version_bytes = d[15:0];
        REG_IDENT:       regs.identifier_prefix = d;
        REG_EXIT_ON_E:   regs.exit_on_e = d[0];
        REG_EXT_ADDR:    regs.extended_address_enable = d[0];
        default: ;
      endcase
    endfunction

    function void put(kind_t k, logic [24:0] a, logic [15:0] p);
      reply_t r;
      if (batch.size() < 7) begin
        r.kind = k; r.addr = a; r.pay = p; r.last = 1'b0;
        batch.push_back(r);
      end
    endfunction

    function void say(logic [7:0] b);
      put(K_SEND, '0, {8'h00, b});
    endfunction

    // flash size is 2^25, so the boot start always bounds the erase walk
    function logic [25:0] erase_end();
      return {1'b0, regs.boot_base};
    endfunction

    function void flash_block_done();
      put(K_PWRITE, flash_addr, '0);
      flash_addr = walk;
      say("\r");
      phase = P_IDLE;
    endfunction

    function void command(logic [7:0] c);
      case (c)
        "P", "L": say("\r");
        "E": begin
          say("\r");
          if (regs.exit_on_e) put(K_START, '0, '0);
        end
        8'h00, "X": begin
          say("\r");
          put(K_START, '0, '0);
        end
        "a": say("Y");
        "A": phase = P_A1;
        "H": if (regs.extended_address_enable) phase = P_H1; else say("?");
        "e": begin
          walk = '0;
          if (erase_end() > 0) begin
            put(K_ERASE, '0, '0);
            ack_wait = 1; phase = P_ERASE;
          end else begin
            flash_addr = '0;
            say("\r");
          end
        end
        "T": phase = P_T;
        "s": begin
          say(regs.signature_bytes[23:16]);
          say(regs.signature_bytes[15:8]);
          say(regs.signature_bytes[7:0]);
        end
        "t": begin
          say(regs.device_code);
          say(8'h00);
        end
        "S": begin
          for (int i = 4; i >= 0; i--) say(regs.identifier_prefix[8*i +: 8]);
          say(regs.version_bytes[15:8]);
          say(regs.version_bytes[7:0]);
        end
        "V": begin
          say(regs.version_bytes[15:8]);
          say(regs.version_bytes[7:0]);
        end
        "p": say("S");
        "b": begin
          say("Y");
          say(regs.block_limit[15:8]);
          say(regs.block_limit[7:0]);
        end
        "B": phase = P_B1;
        "g": phase = P_G1;
        default: say("?");
      endcase
    endfunction

    function void serial_byte(logic [7:0] b);
      case (phase)
        P_A1: begin held = b; phase = P_A2; end
        P_A2: begin
          ee_addr = {held, b};
          flash_addr = {8'h00, ee_addr, 1'b0};
          say("\r"); phase = P_IDLE;
        end
        P_H1: begin walk = {1'b0, b, 16'h0000}; phase = P_H2; end
        P_H2: begin walk[15:8] = b; phase = P_H3; end
        P_H3: begin
          walk[7:0] = b;
          flash_addr = {walk[23:0], 1'b0};
          ee_addr = '0;
          say("\r"); phase = P_IDLE;
        end
        P_T: begin say("\r"); phase = P_IDLE; end
        P_B1: begin held = b; phase = P_B2; end
        P_B2: begin
          blen = {held, b};
          if (blen > regs.block_limit) begin say("?"); phase = P_IDLE; end
          else phase = P_BTYPE;
        end
        P_BTYPE: begin
          if (b == "F") begin
            if (flash_addr > regs.boot_base) say(8'h00);
            walk = flash_addr;
            remain = blen >> 1;
            if (remain == 0) flash_block_done(); else phase = P_FLO;
          end else if (b == "E") begin
            remain = blen;
            if (remain == 0) begin say("\r"); phase = P_IDLE; end
            else phase = P_EDATA;
          end else begin
            say("?"); phase = P_IDLE;
          end
        end
        P_FLO: begin held = b; phase = P_FHI; end
        P_FHI: begin
          put(K_FILL, walk, {b, held});
          walk = (walk + 25'd2) & FLASH_MASK;
          remain = remain - 16'd1;
          if (remain == 0) flash_block_done(); else phase = P_FLO;
        end
        P_EDATA: begin
          put(K_EWRITE, {9'h000, ee_addr}, {8'h00, b});
          ee_addr = ee_addr + 16'd1;
          remain = remain - 16'd1;
          if (remain == 0) begin say("\r"); phase = P_IDLE; end
        end
        P_G1: begin held = b; phase = P_G2; end
        P_G2: begin blen = {held, b}; phase = P_GTYPE; end
        P_GTYPE: begin
          phase = P_IDLE;
          if (b == "F") begin
            remain = 16'((17'(blen) + 17'd1) >> 1);
            if (remain != 0) begin
              put(K_FREAD, flash_addr, '0);
              ack_wait = 1; phase = P_RDF;
            end
          end else if (b == "E") begin
            remain = blen;
            if (remain != 0) begin
              put(K_EREAD, {9'h000, ee_addr}, '0);
              ack_wait = 1; phase = P_RDE;
            end
          end else say("?");
        end
        P_IDLE: command(b);
        default: phase = P_IDLE;
      endcase
    endfunction

    function void mem_ack(logic [15:0] v);
      logic [25:0] nxt;
      ack_wait = 0;
      if (phase == P_ERASE) begin
        nxt = {1'b0, walk} + 26'(PAGE_BYTES);
        if (nxt < erase_end()) begin
          walk = nxt[24:0];
          put(K_ERASE, walk, '0);
          ack_wait = 1;
        end else begin
          flash_addr = nxt[24:0];
          say("\r"); phase = P_IDLE;
        end
      end else if (phase == P_RDF) begin
        say(v[7:0]);
        say(v[15:8]);
        flash_addr = (flash_addr + 25'd2) & FLASH_MASK;
        remain = remain - 16'd1;
        if (remain != 0) begin
          put(K_FREAD, flash_addr, '0);
          ack_wait = 1;
        end else phase = P_IDLE;
      end else if (phase == P_RDE) begin
        say(v[7:0]);
        ee_addr = ee_addr + 16'd1;
        remain = remain - 16'd1;
        if (remain != 0) begin
          put(K_EREAD, {9'h000, ee_addr}, '0);
          ack_wait = 1;
        end else phase = P_IDLE;
      end else phase = P_IDLE;
    endfunction

    // note one accepted input transaction
    function void note_input(logic op, logic [15:0] v);
      batch.delete();
      if (op) begin
        if (ack_wait) mem_ack(v);
      end else if (!ack_wait) serial_byte(v[7:0]);
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) pending.push_back(batch[i]);
    endfunction

    task check_result(kind_t k, logic [24:0] a, logic [15:0] p, logic l);
      reply_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result kind %0d addr %h pay %h", k, a, p));
        return;
      end
      e = pending.pop_front();
      if (k != e.kind) report($sformatf("kind %0d, want %0d", k, e.kind));
      if (a != e.addr) report($sformatf("mem_address %h, want %h", a, e.addr));
      if (p != e.pay) report($sformatf("payload %h, want %h", p, e.pay));
      if (l != e.last) report($sformatf("last %0b, want %0b", l, e.last));
    endtask
  endclass

  engine_scoreboard board = new();

  // gap length: mostly short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result side: sample at the edge, then choose the next stall
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      board.check_result(kind_t'(out_kind), out_mem_address, out_payload, out_last);
      results_seen++;
    end
    if (!stall_mode) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < 25) ? 1'b1 :
                      ($urandom_range(0, 99) < 3);
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // one input transaction; waits for acceptance, valid stays up for a
  // back-to-back follower and drops at the start of a gap
  task automatic send_item(input logic op, input logic [15:0] v);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(op, v);
  endtask

  task automatic serial(input logic [7:0] b);
    send_item(1'b0, {8'($urandom_range(0, 255)), b});
  endtask

  // acks while the engine waits on memory, random read data
  task automatic answer_acks();
    while (board.ack_wait) send_item(1'b1, 16'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [2:0] idx, input logic [39:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    board.write_reg(idx, d);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_all(input logic extreme_high);
    write_cfg(REG_BLOCK_LIMIT, extreme_high ? 40'hFFFF : 40'($urandom_range(0, 40)));
    write_cfg(REG_BOOT_START, extreme_high ? 40'h1FF_FFFF : 40'($urandom_range(0, 4) * 256));
    write_cfg(REG_SIGNATURE, extreme_high ? 40'hFF_FFFF : 40'($urandom & 24'hFFFFFF));
    write_cfg(REG_DEVICE, extreme_high ? 40'hFF : 40'($urandom_range(0, 255)));
    write_cfg(REG_VERSION, extreme_high ? 40'hFFFF : 40'($urandom_range(0, 65535)));
    write_cfg(REG_IDENT, extreme_high ? 40'hFF_FFFF_FFFF : {8'($urandom), 32'($urandom)});
    write_cfg(REG_EXIT_ON_E, 40'($urandom_range(0, 1)));
    write_cfg(REG_EXT_ADDR, extreme_high ? 40'h1 : 40'($urandom_range(0, 1)));
  endtask

  // a command with random arguments, at times a bad type or length; sizes kept small
  task automatic random_command();
    logic [7:0] cmds[16] = '{"P", "L", "E", "a", "A", "H", "e", "T",
                             "s", "t", "S", "V", "p", "b", "B", "g"};
    logic [7:0] c;
    int n;
    c = cmds[$urandom_range(0, 15)];
    if (c == "e" && board.regs.boot_base > 25'd2048) c = "p";
    serial(c);
    case (c)
      "A": begin serial(8'($urandom)); serial(8'($urandom)); end
      "H": if (board.regs.extended_address_enable) begin
        serial(8'($urandom)); serial(8'($urandom)); serial(8'($urandom));
      end
      "T": serial(8'($urandom));
      "B": begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 9);
        serial(8'(n >> 8)); serial(8'(n));
        if (n <= board.regs.block_limit) begin
          serial(($urandom_range(0, 9) == 0) ? 8'($urandom) :
                 ($urandom_range(0, 1) ? "F" : "E"));
          while (board.phase inside {P_FLO, P_FHI, P_EDATA}) serial(8'($urandom));
        end
      end
      "g": begin
        n = $urandom_range(0, 6);
        serial(8'(n >> 8)); serial(8'(n));
        serial(($urandom_range(0, 9) == 0) ? 8'($urandom) :
               ($urandom_range(0, 1) ? "F" : "E"));
      end
      default: ;
    endcase
    answer_acks();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every command but e with reset settings, then edge cases
    serial(8'h00);
    serial("X");
    serial("a"); serial("P"); serial("L"); serial("E"); serial("T"); serial(8'hFF);
    serial("s"); serial("t"); serial("S"); serial("V"); serial("p"); serial("b");
    serial("H"); serial("z");
    serial("A"); serial(8'hFF); serial(8'hFF);            // highest word address
    send_item(1'b1, 16'hFFFF);                             // ack with none pending
    serial("B"); serial(8'h00); serial(8'h03); serial("F"); // odd size, above boot
    serial(8'h11); serial(8'h22);
    serial("B"); serial(8'hFF); serial(8'hFF);            // over the limit
    serial("B"); serial(8'h00); serial(8'h00); serial("Q"); // bad memory type
    serial("g"); serial(8'h00); serial(8'h00); serial("F"); // zero-size read
    serial("g"); serial(8'h00); serial(8'h03); serial("F"); answer_acks();
    serial("g"); serial(8'h00); serial(8'h02); serial("E");
    serial("p");                                           // stray byte during read
    answer_acks();
    drain();

    // extremes: all-ones registers but exit_on_e, extended address and erase walks
    set_all(1'b1);
    serial("H"); serial(8'hFF); serial(8'hFF); serial(8'hFF);
    serial("S"); serial("b"); serial("E");
    serial("A"); serial(8'hFF); serial(8'hFF);
    serial("g"); serial(8'h00); serial(8'h03); serial("E"); // eeprom address wraps
    answer_acks();
    serial("A"); serial(8'h00); serial(8'h00);
    drain();
    write_cfg(REG_BOOT_START, 40'd0);                      // empty erase walk
    serial("e");
    drain();
    write_cfg(REG_BOOT_START, 40'd1280);
    serial("e"); answer_acks();
    drain();
    write_cfg(REG_BLOCK_LIMIT, 40'd0);
    serial("B"); serial(8'h00); serial(8'h00); serial("E");
    serial("B"); serial(8'h00); serial(8'h01); serial("F");
    drain();

    // random phases with fresh settings between them
    for (int ph = 0; ph < 6; ph++) begin
      set_all(1'b0);
      stall_mode = (ph != 2);
      for (int k = 0; k < 20; k++) begin
        if ($urandom_range(0, 19) == 0) send_item(1'($urandom_range(0, 1)), 16'($urandom));
        else random_command();
      end
      answer_acks();
      while (board.phase != P_IDLE) begin
        serial(8'($urandom));
        answer_acks();
      end
      drain();
    end

    stall_mode = 1'b1;
    drain();
    $display("covered all commands, block load and read of both memories, erase walks,");
    $display("stray inputs and %0d checked results over %0d cycles", results_seen, cycles);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: serial_programming_command_engine.f
rtl/spce_pkg.sv
rtl/spce_front.sv
rtl/spce_queue.sv
rtl/spce_back.sv
rtl/serial_programming_command_engine.sv
tb/serial_programming_command_engine_test.sv
